[rtl/gn3d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn3d_pkg
// Shared constants and permutation ROM for the noise block.
// ----------------------------------------------------------------------------
package gn3d_pkg;

    localparam int CELL_BITS = 8;
    localparam int COORD_W   = 32;
    localparam int NOISE_W   = 18;

    typedef logic [CELL_BITS-1:0] cell_t;

    localparam logic [7:0] PERM_ROM [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13,
        8'd201, 8'd95, 8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225,
        8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142, 8'd8, 8'd99,
        8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190, 8'd6, 8'd148,
        8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
        8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32,
        8'd57, 8'd177, 8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87,
        8'd174, 8'd20, 8'd125, 8'd136, 8'd171, 8'd168, 8'd68, 8'd175,
        8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48, 8'd27, 8'd166,
        8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
        8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41,
        8'd55, 8'd46, 8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54,
        8'd65, 8'd25, 8'd63, 8'd161, 8'd1, 8'd216, 8'd80, 8'd73,
        8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89, 8'd18, 8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64,
        8'd52, 8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202,
        8'd38, 8'd147, 8'd118, 8'd126, 8'd255, 8'd82, 8'd85, 8'd212,
        8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58, 8'd17,
        8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9,
        8'd129, 8'd22, 8'd39, 8'd253, 8'd19, 8'd98, 8'd108, 8'd110,
        8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241,
        8'd81, 8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107,
        8'd49, 8'd192, 8'd214, 8'd31, 8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121, 8'd50, 8'd45,
        8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141,
        8'd128, 8'd195, 8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
    };

endpackage

[rtl/gn3d_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn3d_stream_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface gn3d_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/gn3d_fade.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn3d_fade
// Pipelined quintic fade 6t^5-15t^4+10t^3, three register stages.
// ----------------------------------------------------------------------------
module gn3d_fade #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [FRAC_BITS-1:0] frac,
    output logic [FRAC_BITS:0]   weight
);
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * F + 8;

    logic [F-1:0] f1_reg;
    logic [F-1:0] t2_reg;
    logic [F+3:0] bsub_reg;
    logic [F-1:0] t3_reg;
    logic [F+3:0] b_reg;
    logic [F:0]   w_reg;

    logic [PW-1:0] t2_full, t3_full, bq_full, w_full;
    logic [F+4:0]  lin;

    always_comb
    begin
        t2_full = PW'(frac) * PW'(frac);
        // 15*one - 6f, always positive
        lin     = (F+5)'(15) << F;
        lin     = lin - (F+5)'(6) * (F+5)'(frac);
        bq_full = PW'(lin) * PW'(frac);
        t3_full = PW'(t2_reg) * PW'(f1_reg);
        w_full  = PW'(t3_reg) * PW'(b_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg   <= frac;
            t2_reg   <= F'(t2_full >> F);
            bsub_reg <= (F+4)'(bq_full >> F);
            t3_reg   <= F'(t3_full >> F);
            b_reg    <= ((F+4)'(10) << F) - bsub_reg;
            w_reg    <= (F+1)'(w_full >> F);
        end
    end

    assign weight = w_reg;
endmodule

[rtl/gradient_noise_3d.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_3d
// Improved 3D gradient noise in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// One point is taken per clock and passes through these stages in order:
// one stage splits the coordinates, three stages walk the permutation ROM
// hash chain, three stages form the fade weights and corner gradients,
// then x, y and z blends take one stage each with a final saturate. A
// stall on the output freezes the whole pipeline, so throughput is one
// transaction per cycle whenever the output side is ready.
module gradient_noise_3d #(
    parameter int FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    gn3d_stream_if.sink   in_ch,
    gn3d_stream_if.source out_ch
);
    import gn3d_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int DEPTH = 10;
    localparam int GW    = F + 3;   // corner gradient width
    localparam int LW    = F + 6;   // blend value width

    logic en;
    logic [DEPTH-1:0] vld_reg, vld_next;

    assign en          = out_ch.ready || !vld_reg[DEPTH-1];
    assign in_ch.ready = en;

    always_comb
    begin
        vld_next = {vld_reg[DEPTH-2:0], in_ch.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    // stage 0: split coordinates
    logic [F-1:0] fx0_reg, fy0_reg, fz0_reg;
    cell_t cx0_reg, cy0_reg, cz0_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fx0_reg <= in_ch.data.coord_x[F-1:0];
            fy0_reg <= in_ch.data.coord_y[F-1:0];
            fz0_reg <= in_ch.data.coord_z[F-1:0];
            cx0_reg <= in_ch.data.coord_x[F+7:F];
            cy0_reg <= in_ch.data.coord_y[F+7:F];
            cz0_reg <= in_ch.data.coord_z[F+7:F];
        end
    end

    // fractions travel alongside the hash stages
    logic [F-1:0] fx_d_reg [3], fy_d_reg [3], fz_d_reg [3];
    cell_t cy1_reg, cz1_reg, cz2_reg;
    cell_t hx_reg [2];
    cell_t hxy_reg [4];
    logic [3:0] h_reg [8];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fx_d_reg[0] <= fx0_reg; fy_d_reg[0] <= fy0_reg; fz_d_reg[0] <= fz0_reg;
            for (int i = 1; i < 3; i++)
            begin
                fx_d_reg[i] <= fx_d_reg[i-1];
                fy_d_reg[i] <= fy_d_reg[i-1];
                fz_d_reg[i] <= fz_d_reg[i-1];
            end
            cy1_reg <= cy0_reg;
            cz1_reg <= cz0_reg;
            cz2_reg <= cz1_reg;
            hx_reg[0] <= PERM_ROM[cx0_reg];
            hx_reg[1] <= PERM_ROM[cell_t'(cx0_reg + 8'd1)];
            for (int k = 0; k < 4; k++)
                hxy_reg[k] <= PERM_ROM[cell_t'(hx_reg[k[0]] + cy1_reg + cell_t'(k[1]))];
            for (int k = 0; k < 8; k++)
                h_reg[k] <= PERM_ROM[cell_t'(hxy_reg[k[1:0]] + cz2_reg
                                             + cell_t'(k[2]))][3:0];
        end
    end

    // fade units, weights valid in stage 6 (entering at stage 3)
    logic [F:0] wx, wy, wz;
    gn3d_fade #(.FRAC_BITS(F)) u_fade_x
        (.clk(clk), .en(en), .frac(fx_d_reg[2]), .weight(wx));
    gn3d_fade #(.FRAC_BITS(F)) u_fade_y
        (.clk(clk), .en(en), .frac(fy_d_reg[2]), .weight(wy));
    gn3d_fade #(.FRAC_BITS(F)) u_fade_z
        (.clk(clk), .en(en), .frac(fz_d_reg[2]), .weight(wz));

    // stage 4: corner gradients
    logic signed [GW-1:0] g_reg [8];
    logic signed [GW-1:0] g_next [8];
    always_comb
    begin
        logic signed [GW-1:0] dx, dy, dz, u, v;
        logic [3:0] h;
        for (int k = 0; k < 8; k++)
        begin
            h  = h_reg[k];
            dx = k[0] ? $signed({3'b111, fx_d_reg[2]}) : $signed({3'b000, fx_d_reg[2]});
            dy = k[1] ? $signed({3'b111, fy_d_reg[2]}) : $signed({3'b000, fy_d_reg[2]});
            dz = k[2] ? $signed({3'b111, fz_d_reg[2]}) : $signed({3'b000, fz_d_reg[2]});
            u  = (h < 4'd8 || h == 4'd12 || h == 4'd13) ? dx : dy;
            v  = (h < 4'd4 || h == 4'd12 || h == 4'd13) ? dy : dz;
            if (h[0]) u = -u;
            if (h[1]) v = -v;
            g_next[k] = u + v;
        end
    end

    // gradients wait for the fade (stages 4..6)
    logic signed [GW-1:0] gd_reg [2][8];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg <= g_next;
            gd_reg[0] <= g_reg;
            gd_reg[1] <= gd_reg[0];
        end
    end

    // blend stages; wy and wz are delayed to line up
    logic [F:0] wy_d_reg, wz_d1_reg, wz_d2_reg;
    logic signed [LW-1:0] x_reg [4];
    logic signed [LW-1:0] y_reg [2];
    logic signed [LW-1:0] r_reg;

    function automatic logic signed [LW-1:0] lerp(input logic [F:0] w,
                                                  input logic signed [LW-1:0] a,
                                                  input logic signed [LW-1:0] b);
        logic signed [LW+F+2:0] p;
        p = $signed({1'b0, w}) * (b - a);
        return a + LW'(p >>> F);
    endfunction

    // fade outputs arrive together with the last gradient delay,
    // so x blends take gd_reg[1] together with wx
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
                x_reg[k] <= lerp(wx, LW'(gd_reg[1][2*k]), LW'(gd_reg[1][2*k+1]));
            wy_d_reg  <= wy;
            wz_d1_reg <= wz;
            y_reg[0]  <= lerp(wy_d_reg, x_reg[0], x_reg[1]);
            y_reg[1]  <= lerp(wy_d_reg, x_reg[2], x_reg[3]);
            wz_d2_reg <= wz_d1_reg;
            r_reg     <= lerp(wz_d2_reg, y_reg[0], y_reg[1]);
        end
    end

    // saturate
    logic signed [NOISE_W-1:0] sat;
    always_comb
    begin
        if (r_reg > LW'(131071))
            sat = 18'sd131071;
        else if (r_reg < -LW'(131072))
            sat = -18'sd131072;
        else
            sat = NOISE_W'(r_reg);
    end

    assign out_ch.valid           = vld_reg[DEPTH-1];
    assign out_ch.data.noise_value = sat;
endmodule
